// File: hdl/vgi_pkg.sv
package vgi_pkg;

   localparam int COORD_W    = 21;
   localparam int RES_W      = 12;
   localparam int INFL_W     = 3;
   localparam int CHK_W      = 4;
   localparam int MODE_W     = 2;
   localparam int CNT_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;
   localparam int POS_W      = 32;
   localparam int DVD_W      = 22;
   localparam int MAG_W      = 21;
   localparam int QUO_W      = 23;
   localparam int REM_W      = 12;
   localparam int STEP_W     = 6;
   localparam int RAD_W      = 5;
   localparam int DCNT_W     = 5;

   localparam logic [CNT_W-1:0] NEAR_LIMIT = 10'd5;

   localparam logic [MODE_W-1:0] MODE_OBSTACLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEIGHBOR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RES      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INFLATE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_LOW    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_HIGH   = 3'd6;

   localparam logic signed [COORD_W-1:0] ORIGIN_X_RST = -21'sd5000;
   localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST = -21'sd5000;
   localparam logic signed [COORD_W-1:0] ORIGIN_Z_RST = 21'sd0;
   localparam logic [RES_W-1:0]          RES_RST      = 12'd200;
   localparam logic [INFL_W-1:0]         INFLATE_RST  = 3'd2;
   localparam logic signed [COORD_W-1:0] Z_LOW_RST    = 21'sd800;
   localparam logic signed [COORD_W-1:0] Z_HIGH_RST   = 21'sd1200;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CENTER,
      S_DIV_GO,
      S_DIV_WAIT,
      S_INIT,
      S_BACK,
      S_FILL,
      S_SCAN_A,
      S_SCAN_B,
      S_SCAN_C,
      S_DONE
   } vgi_state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic center;
      logic div_start;
      logic div_store;
      logic init;
      logic back;
      logic fill;
      logic read;
      logic count;
      logic advance;
      logic set_safe;
      logic load_rsp;
   } vgi_cmd_type;

   typedef struct packed {
      logic              clr_done;
      logic              inside_now;
      logic              div_done;
      logic              axis_last;
      logic              back_done;
      logic              loop_done;
      logic              st_inmap;
      logic              rsp_free;
      logic [MODE_W-1:0] mode;
   } vgi_sts_type;

endpackage

// File: hdl/voxel_grid_inflate_and_safety_check.sv
// Channel  Direction  Ports
// req      in         req_valid, req_stall, req_mode, req_x_mm, req_y_mm, req_z_mm,
//                     req_check_cells
// rsp      out        rsp_valid, rsp_stall, rsp_in_map, rsp_safe, rsp_occupied_count
// csr      in         csr_write, csr_index, csr_data
//
// After reset the grid is cleared one cell per cycle, all GRID_X*GRID_Y*GRID_Z cells
// (131072 at the defaults), before the first request is taken.
// An obstacle or query request outside the map, or one of the unused mode, goes
// straight to the response. Otherwise setup is accept, map test, three serial index
// divisions and loop init, then a step back to the corner; insert modes then write
// one cell per cycle over the (2R+1)^3 cells of radius R; the query scans at most
// (2C+1)^2 cells; then the response register is loaded. One request is in work at a time; a
// finished response waits in the output register while the next request is taken,
// and a held rsp_stall holds the controller in its last state until the register frees.
module voxel_grid_inflate_and_safety_check #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [vgi_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [vgi_pkg::COORD_W-1:0]     req_x_mm,
   input  logic signed [vgi_pkg::COORD_W-1:0]     req_y_mm,
   input  logic signed [vgi_pkg::COORD_W-1:0]     req_z_mm,
   input  logic [vgi_pkg::CHK_W-1:0]              req_check_cells,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_in_map,
   output logic                                   rsp_safe,
   output logic [vgi_pkg::CNT_W-1:0]              rsp_occupied_count,
   input  logic                                   csr_write,
   input  logic [vgi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [vgi_pkg::CSR_DATA_W-1:0]         csr_data
);

   vgi_pkg::vgi_cmd_type cmd;
   vgi_pkg::vgi_sts_type sts;

   vgi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vgi_dp #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_x_mm           (req_x_mm),
      .req_y_mm           (req_y_mm),
      .req_z_mm           (req_z_mm),
      .req_check_cells    (req_check_cells),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_in_map         (rsp_in_map),
      .rsp_safe           (rsp_safe),
      .rsp_occupied_count (rsp_occupied_count)
   );

endmodule

// File: hdl/vgi_div.sv
module vgi_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [vgi_pkg::DVD_W-1:0]     dividend,
   input  logic [vgi_pkg::RES_W-1:0]            divisor,
   output logic                                 done,
   output logic signed [vgi_pkg::QUO_W-1:0]     quotient,
   output logic [vgi_pkg::REM_W-1:0]            remainder
);

   logic                           busy_ff;
   logic                           done_ff;
   logic                           neg_ff;
   logic [vgi_pkg::MAG_W-1:0]      mag_ff;
   logic [vgi_pkg::REM_W-1:0]      part_ff;
   logic [vgi_pkg::MAG_W-1:0]      acc_ff;
   logic [vgi_pkg::DCNT_W-1:0]     cnt_ff;
   logic signed [vgi_pkg::QUO_W-1:0] quo_ff;
   logic [vgi_pkg::REM_W-1:0]      rem_ff;

   logic signed [vgi_pkg::DVD_W-1:0] abs_val;
   logic [vgi_pkg::REM_W:0]        trial;
   logic [vgi_pkg::REM_W:0]        dsr;
   logic                           ge;
   logic [vgi_pkg::REM_W:0]        diff;
   logic [vgi_pkg::QUO_W-1:0]      acc_ext;

   assign abs_val = dividend[vgi_pkg::DVD_W-1] ? -dividend : dividend;
   assign trial   = {part_ff, mag_ff[vgi_pkg::MAG_W-1]};
   assign dsr     = {1'b0, divisor};
   assign ge      = trial >= dsr;
   assign diff    = trial - dsr;
   assign acc_ext = {{(vgi_pkg::QUO_W-vgi_pkg::MAG_W){1'b0}}, acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= vgi_pkg::DCNT_W'(vgi_pkg::MAG_W);
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[vgi_pkg::DVD_W-1];
         mag_ff  <= abs_val[vgi_pkg::MAG_W-1:0];
         part_ff <= '0;
         acc_ff  <= '0;
      end else if (busy_ff && cnt_ff != '0) begin
         mag_ff  <= {mag_ff[vgi_pkg::MAG_W-2:0], 1'b0};
         part_ff <= ge ? diff[vgi_pkg::REM_W-1:0] : trial[vgi_pkg::REM_W-1:0];
         acc_ff  <= {acc_ff[vgi_pkg::MAG_W-2:0], ge};
      end else if (busy_ff) begin
         // round toward minus infinity
         if (neg_ff && part_ff != '0) begin
            quo_ff <= $signed(~acc_ext);
            rem_ff <= divisor - part_ff;
         end else if (neg_ff) begin
            quo_ff <= $signed(-acc_ext);
            rem_ff <= '0;
         end else begin
            quo_ff <= $signed(acc_ext);
            rem_ff <= part_ff;
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/vgi_dp.sv
module vgi_dp #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  vgi_pkg::vgi_cmd_type                   cmd,
   output vgi_pkg::vgi_sts_type                   sts,
   input  logic [vgi_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [vgi_pkg::COORD_W-1:0]     req_x_mm,
   input  logic signed [vgi_pkg::COORD_W-1:0]     req_y_mm,
   input  logic signed [vgi_pkg::COORD_W-1:0]     req_z_mm,
   input  logic [vgi_pkg::CHK_W-1:0]              req_check_cells,
   input  logic                                   csr_write,
   input  logic [vgi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [vgi_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic                                   rsp_in_map,
   output logic                                   rsp_safe,
   output logic [vgi_pkg::CNT_W-1:0]              rsp_occupied_count
);

   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int XW    = $clog2(GRID_X + 1);
   localparam int YW    = $clog2(GRID_Y + 1);
   localparam int ZW    = $clog2(GRID_Z + 1);
   localparam int GYZ   = GRID_Y * GRID_Z;
   localparam int PW    = vgi_pkg::POS_W;
   localparam int RZ_W  = vgi_pkg::RES_W + 3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   function automatic logic in_box(
      input logic signed [PW-1:0] px, py, pz,
      input logic signed [PW-1:0] xl, xh, yl, yh, zl, zh
   );
      return (px > xl) && (px < xh) && (py > yl) && (py < yh) && (pz > zl) && (pz < zh);
   endfunction

   // configuration
   logic signed [vgi_pkg::COORD_W-1:0] org_x_ff, org_y_ff, org_z_ff, z_low_ff, z_high_ff;
   logic [vgi_pkg::RES_W-1:0]          res_ff;
   logic [vgi_pkg::INFL_W-1:0]         infl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff  <= vgi_pkg::ORIGIN_X_RST;
         org_y_ff  <= vgi_pkg::ORIGIN_Y_RST;
         org_z_ff  <= vgi_pkg::ORIGIN_Z_RST;
         res_ff    <= vgi_pkg::RES_RST;
         infl_ff   <= vgi_pkg::INFLATE_RST;
         z_low_ff  <= vgi_pkg::Z_LOW_RST;
         z_high_ff <= vgi_pkg::Z_HIGH_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            vgi_pkg::CSR_ORIGIN_X: org_x_ff  <= $signed(csr_data);
            vgi_pkg::CSR_ORIGIN_Y: org_y_ff  <= $signed(csr_data);
            vgi_pkg::CSR_ORIGIN_Z: org_z_ff  <= $signed(csr_data);
            vgi_pkg::CSR_RES:      res_ff    <= csr_data[vgi_pkg::RES_W-1:0];
            vgi_pkg::CSR_INFLATE:  infl_ff   <= csr_data[vgi_pkg::INFL_W-1:0];
            vgi_pkg::CSR_Z_LOW:    z_low_ff  <= $signed(csr_data);
            vgi_pkg::CSR_Z_HIGH:   z_high_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   logic [vgi_pkg::RES_W-1:0] res;
   logic signed [PW-1:0]      r32, r2_32;
   logic signed [RZ_W-1:0]    r14, r2_14;

   assign res   = (res_ff == '0) ? {{(vgi_pkg::RES_W-1){1'b0}}, 1'b1} : res_ff;
   assign r32   = $signed({{(PW-vgi_pkg::RES_W){1'b0}}, res});
   assign r2_32 = $signed({{(PW-vgi_pkg::RES_W-1){1'b0}}, res, 1'b0});
   assign r14   = $signed({3'b000, res});
   assign r2_14 = $signed({2'b00, res, 1'b0});

   // map bounds in half millimetres
   logic signed [PW-1:0] ox32, oy32, zl32, zh32, gxr, gyr;
   logic signed [PW-1:0] bxl_ff, bxh_ff, byl_ff, byh_ff, bzl_ff, bzh_ff;

   assign ox32 = $signed({{(PW-vgi_pkg::COORD_W){org_x_ff[vgi_pkg::COORD_W-1]}}, org_x_ff});
   assign oy32 = $signed({{(PW-vgi_pkg::COORD_W){org_y_ff[vgi_pkg::COORD_W-1]}}, org_y_ff});
   assign zl32 = $signed({{(PW-vgi_pkg::COORD_W){z_low_ff[vgi_pkg::COORD_W-1]}}, z_low_ff});
   assign zh32 = $signed({{(PW-vgi_pkg::COORD_W){z_high_ff[vgi_pkg::COORD_W-1]}}, z_high_ff});
   assign gxr  = $signed(PW'(GRID_X) * r32);
   assign gyr  = $signed(PW'(GRID_Y) * r32);

   always_ff @(posedge clock) begin
      bxl_ff <= ox32 <<< 1;
      bxh_ff <= (ox32 + gxr) <<< 1;
      byl_ff <= oy32 <<< 1;
      byh_ff <= (oy32 + gyr) <<< 1;
      bzl_ff <= zl32 <<< 1;
      bzh_ff <= zh32 <<< 1;
   end

   // request registers
   logic [vgi_pkg::MODE_W-1:0]         pt_mode_ff;
   logic signed [vgi_pkg::COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;
   logic [vgi_pkg::CHK_W-1:0]          pt_chk_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pt_mode_ff <= req_mode;
         pt_x_ff    <= req_x_mm;
         pt_y_ff    <= req_y_mm;
         pt_z_ff    <= req_z_mm;
         pt_chk_ff  <= req_check_cells;
      end
   end

   logic signed [PW-1:0] x2, y2, z2;
   assign x2 = $signed({{(PW-vgi_pkg::COORD_W-1){pt_x_ff[vgi_pkg::COORD_W-1]}}, pt_x_ff, 1'b0});
   assign y2 = $signed({{(PW-vgi_pkg::COORD_W-1){pt_y_ff[vgi_pkg::COORD_W-1]}}, pt_y_ff, 1'b0});
   assign z2 = $signed({{(PW-vgi_pkg::COORD_W-1){pt_z_ff[vgi_pkg::COORD_W-1]}}, pt_z_ff, 1'b0});

   logic inside_now;
   assign inside_now = in_box(x2, y2, z2, bxl_ff, bxh_ff, byl_ff, byh_ff, bzl_ff, bzh_ff);

   // cell index of the request, one axis at a time
   logic [1:0]                          axis_ff;
   logic signed [vgi_pkg::DVD_W-1:0]    dvd;
   logic                                div_start;
   logic                                div_done;
   logic signed [vgi_pkg::QUO_W-1:0]    quo;
   logic [vgi_pkg::REM_W-1:0]           rem;
   logic signed [PW-1:0]                q32;
   logic signed [PW-1:0]                qx_ff, qy_ff, qz_ff;
   logic [vgi_pkg::REM_W-1:0]           mx_ff, my_ff, mz_ff;

   always_comb begin
      case (axis_ff)
         AXIS_X:  dvd = $signed({pt_x_ff[vgi_pkg::COORD_W-1], pt_x_ff})
                      - $signed({org_x_ff[vgi_pkg::COORD_W-1], org_x_ff});
         AXIS_Y:  dvd = $signed({pt_y_ff[vgi_pkg::COORD_W-1], pt_y_ff})
                      - $signed({org_y_ff[vgi_pkg::COORD_W-1], org_y_ff});
         default: dvd = $signed({pt_z_ff[vgi_pkg::COORD_W-1], pt_z_ff})
                      - $signed({org_z_ff[vgi_pkg::COORD_W-1], org_z_ff});
      endcase
   end

   assign div_start = cmd.div_start;

   vgi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (res),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   assign q32 = $signed({{(PW-vgi_pkg::QUO_W){quo[vgi_pkg::QUO_W-1]}}, quo});

   always_ff @(posedge clock) begin
      if (cmd.center) begin
         axis_ff <= AXIS_X;
      end else if (cmd.div_store) begin
         axis_ff <= axis_ff + 2'd1;
         case (axis_ff)
            AXIS_X: begin
               qx_ff <= q32;
               mx_ff <= rem;
            end
            AXIS_Y: begin
               qy_ff <= q32;
               my_ff <= rem;
            end
            default: begin
               qz_ff <= q32;
               mz_ff <= rem;
            end
         endcase
      end
   end

   // walk over the neighborhood
   logic signed [PW-1:0]     px_ff, py_ff, pz_ff, ix_ff, iy_ff, iz_ff;
   logic signed [PW-1:0]     py0_ff, pz0_ff, iy0_ff, iz0_ff;
   logic signed [RZ_W-1:0]   rz_ff, rz0_ff;
   logic [vgi_pkg::STEP_W-1:0] cx_ff, cy_ff, cz_ff, lim_xy_ff, lim_z_ff;
   logic [vgi_pkg::RAD_W-1:0]  bk_ff;
   logic                       backz_ff;

   logic [vgi_pkg::RAD_W-1:0]  infl5, rad;
   logic signed [PW-1:0]       mx2, my2, mz2;
   logic signed [RZ_W-1:0]     rz_up_t, rz_dn_t, rz_up, rz_dn;
   logic signed [PW-1:0]       iz_up, iz_dn, py_dn, pz_dn;

   assign infl5 = {{(vgi_pkg::RAD_W-vgi_pkg::INFL_W){1'b0}}, infl_ff};
   assign rad   = (pt_mode_ff == vgi_pkg::MODE_NEIGHBOR) ? infl5 + (infl5 << 1) : infl5;
   assign mx2   = $signed({{(PW-vgi_pkg::REM_W-1){1'b0}}, mx_ff, 1'b0});
   assign my2   = $signed({{(PW-vgi_pkg::REM_W-1){1'b0}}, my_ff, 1'b0});
   assign mz2   = $signed({{(PW-vgi_pkg::REM_W-1){1'b0}}, mz_ff, 1'b0});

   assign rz_up_t = rz_ff + r14;
   assign rz_dn_t = rz_ff - r14;
   assign rz_up   = (rz_up_t >= r2_14) ? rz_up_t - r2_14 : rz_up_t;
   assign iz_up   = (rz_up_t >= r2_14) ? iz_ff + 1 : iz_ff;
   assign rz_dn   = rz_dn_t[RZ_W-1] ? rz_dn_t + r2_14 : rz_dn_t;
   assign iz_dn   = rz_dn_t[RZ_W-1] ? iz_ff - 1 : iz_ff;
   assign py_dn   = py_ff - r2_32;
   assign pz_dn   = pz_ff - r32;

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         ix_ff <= qx_ff;
         iy_ff <= qy_ff;
         iz_ff <= qz_ff;
         iy0_ff <= qy_ff;
         iz0_ff <= qz_ff;
         if (pt_mode_ff == vgi_pkg::MODE_QUERY) begin
            px_ff     <= x2 - mx2 + r32;
            py_ff     <= y2 - my2 + r32;
            pz_ff     <= z2 - mz2 + r32;
            py0_ff    <= y2 - my2 + r32;
            pz0_ff    <= z2 - mz2 + r32;
            rz_ff     <= '0;
            rz0_ff    <= '0;
            lim_xy_ff <= {1'b0, pt_chk_ff, 1'b0};
            lim_z_ff  <= '0;
            bk_ff     <= {1'b0, pt_chk_ff};
            backz_ff  <= 1'b0;
         end else begin
            px_ff     <= x2;
            py_ff     <= y2;
            pz_ff     <= z2;
            py0_ff    <= y2;
            pz0_ff    <= z2;
            rz_ff     <= $signed({2'b00, mz_ff, 1'b0});
            rz0_ff    <= $signed({2'b00, mz_ff, 1'b0});
            lim_xy_ff <= {rad, 1'b0};
            lim_z_ff  <= {rad, 1'b0};
            bk_ff     <= rad;
            backz_ff  <= 1'b1;
         end
      end else if (cmd.back) begin
         bk_ff  <= bk_ff - 1'b1;
         px_ff  <= px_ff - r2_32;
         ix_ff  <= ix_ff - 1;
         py_ff  <= py_dn;
         py0_ff <= py_dn;
         iy_ff  <= iy_ff - 1;
         iy0_ff <= iy_ff - 1;
         if (backz_ff) begin
            pz_ff  <= pz_dn;
            pz0_ff <= pz_dn;
            iz_ff  <= iz_dn;
            iz0_ff <= iz_dn;
            rz_ff  <= rz_dn;
            rz0_ff <= rz_dn;
         end
      end else if (cmd.advance) begin
         if (cz_ff != lim_z_ff) begin
            cz_ff <= cz_ff + 1'b1;
            pz_ff <= pz_ff + r32;
            iz_ff <= iz_up;
            rz_ff <= rz_up;
         end else begin
            cz_ff <= '0;
            pz_ff <= pz0_ff;
            iz_ff <= iz0_ff;
            rz_ff <= rz0_ff;
            if (cy_ff != lim_xy_ff) begin
               cy_ff <= cy_ff + 1'b1;
               py_ff <= py_ff + r2_32;
               iy_ff <= iy_ff + 1;
            end else begin
               cy_ff <= '0;
               py_ff <= py0_ff;
               iy_ff <= iy0_ff;
               cx_ff <= cx_ff + 1'b1;
               px_ff <= px_ff + r2_32;
               ix_ff <= ix_ff + 1;
            end
         end
      end
   end

   // check stage: map test, grid test and address of the current cell
   logic            cur_inmap, cur_ok;
   logic [AW-1:0]   cur_addr;
   logic            st_inmap_ff, st_ok_ff, wr_ff;
   logic [AW-1:0]   st_addr_ff;

   assign cur_inmap = in_box(px_ff, py_ff, pz_ff, bxl_ff, bxh_ff, byl_ff, byh_ff,
                             bzl_ff, bzh_ff);
   assign cur_ok = !ix_ff[PW-1] && (ix_ff < $signed(PW'(GRID_X)))
                && !iy_ff[PW-1] && (iy_ff < $signed(PW'(GRID_Y)))
                && !iz_ff[PW-1] && (iz_ff < $signed(PW'(GRID_Z)));
   assign cur_addr = AW'(AW'(ix_ff[XW-1:0]) * AW'(GYZ) + AW'(iy_ff[YW-1:0]) * AW'(GRID_Z)
                       + AW'(iz_ff[ZW-1:0]));

   always_ff @(posedge clock) begin
      st_inmap_ff <= cur_inmap;
      st_ok_ff    <= cur_ok;
      st_addr_ff  <= cur_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
      end else begin
         wr_ff <= cmd.fill && cur_inmap && cur_ok;
      end
   end

   // occupancy memory
   logic          occ_mem_ff [CELLS];
   logic [AW-1:0] clr_ff;
   logic          rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         occ_mem_ff[clr_ff] <= 1'b0;
      end else if (wr_ff) begin
         occ_mem_ff[st_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read && st_ok_ff) begin
         rd_ff <= occ_mem_ff[st_addr_ff];
      end
   end

   // scan tally and result
   logic                      inside_ff, safe_ff;
   logic [vgi_pkg::CNT_W-1:0] cnt_ff, cnt_nxt;
   logic                      rsp_valid_ff, rsp_in_map_ff, rsp_safe_ff;
   logic [vgi_pkg::CNT_W-1:0] rsp_cnt_ff;

   // a cell off the grid counts as occupied
   assign cnt_nxt = cnt_ff + vgi_pkg::CNT_W'(!st_ok_ff || rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.center) begin
         inside_ff <= inside_now;
         safe_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.count) begin
            cnt_ff <= cnt_nxt;
         end
         if (cmd.set_safe) begin
            safe_ff <= cnt_nxt <= vgi_pkg::NEAR_LIMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_in_map_ff <= inside_ff;
         rsp_safe_ff   <= safe_ff;
         rsp_cnt_ff    <= cnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_map         = rsp_in_map_ff;
   assign rsp_safe           = rsp_safe_ff;
   assign rsp_occupied_count = rsp_cnt_ff;

   assign sts.clr_done   = clr_ff == AW'(CELLS - 1);
   assign sts.inside_now = inside_now;
   assign sts.div_done   = div_done;
   assign sts.axis_last  = axis_ff == AXIS_Z;
   assign sts.back_done  = bk_ff == '0;
   assign sts.loop_done  = (cx_ff == lim_xy_ff) && (cy_ff == lim_xy_ff) && (cz_ff == lim_z_ff);
   assign sts.st_inmap   = st_inmap_ff;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.mode       = pt_mode_ff;

endmodule

// File: hdl/vgi_ctrl.sv
module vgi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vgi_pkg::vgi_sts_type  sts,
   output vgi_pkg::vgi_cmd_type  cmd
);

   vgi_pkg::vgi_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vgi_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         vgi_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_done) state_in = vgi_pkg::S_IDLE;
         end
         vgi_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = vgi_pkg::S_CENTER;
            end
         end
         vgi_pkg::S_CENTER: begin
            cmd.center = 1'b1;
            if (sts.mode == vgi_pkg::MODE_NEIGHBOR ||
                (sts.inside_now && (sts.mode == vgi_pkg::MODE_OBSTACLE ||
                                    sts.mode == vgi_pkg::MODE_QUERY))) begin
               state_in = vgi_pkg::S_DIV_GO;
            end else begin
               state_in = vgi_pkg::S_DONE;
            end
         end
         vgi_pkg::S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = vgi_pkg::S_DIV_WAIT;
         end
         vgi_pkg::S_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               state_in = sts.axis_last ? vgi_pkg::S_INIT : vgi_pkg::S_DIV_GO;
            end
         end
         vgi_pkg::S_INIT: begin
            cmd.init = 1'b1;
            state_in = vgi_pkg::S_BACK;
         end
         vgi_pkg::S_BACK: begin
            if (!sts.back_done) begin
               cmd.back = 1'b1;
            end else if (sts.mode == vgi_pkg::MODE_QUERY) begin
               state_in = vgi_pkg::S_SCAN_A;
            end else begin
               state_in = vgi_pkg::S_FILL;
            end
         end
         vgi_pkg::S_FILL: begin
            cmd.fill    = 1'b1;
            cmd.advance = 1'b1;
            if (sts.loop_done) state_in = vgi_pkg::S_DONE;
         end
         vgi_pkg::S_SCAN_A: begin
            state_in = vgi_pkg::S_SCAN_B;
         end
         vgi_pkg::S_SCAN_B: begin
            // drop out on the first cell outside the map
            if (!sts.st_inmap) begin
               state_in = vgi_pkg::S_DONE;
            end else begin
               cmd.read = 1'b1;
               state_in = vgi_pkg::S_SCAN_C;
            end
         end
         vgi_pkg::S_SCAN_C: begin
            cmd.count   = 1'b1;
            cmd.advance = 1'b1;
            if (sts.loop_done) begin
               cmd.set_safe = 1'b1;
               state_in     = vgi_pkg::S_DONE;
            end else begin
               state_in = vgi_pkg::S_SCAN_A;
            end
         end
         vgi_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = vgi_pkg::S_IDLE;
            end
         end
         default: state_in = vgi_pkg::S_IDLE;
      endcase
   end

endmodule
